@@ rtl/core/pairing_function_codec_core_defines.svh @@
// ----------------------------------------------------------------------------
// Pairing function codec: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PAIRING_FUNCTION_CODEC_CORE_DEFINES_SVH
`define PAIRING_FUNCTION_CODEC_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PFC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/pfc_pkg.sv @@
// ----------------------------------------------------------------------------
// Pairing function codec package
// Widths, numbering codes and the lane record that moves along the cell row.
// ----------------------------------------------------------------------------
`default_nettype none

package pfc_pkg;

    localparam int COORD_WIDTH  = 16;
    localparam int IDX_WIDTH    = 2 * COORD_WIDTH + 2;
    // Radicand is 8m+1 for an index m.
    localparam int RAD_WIDTH    = IDX_WIDTH + 3;
    localparam int ROOT_WIDTH   = (RAD_WIDTH + 1) / 2;
    localparam int RADPAD_WIDTH = 2 * ROOT_WIDTH;
    localparam int REM_WIDTH    = ROOT_WIDTH + 1;
    // Argument of the triangular number s(s+1)/2.
    localparam int TARG_WIDTH   = ROOT_WIDTH - 1;
    localparam int TRI_WIDTH    = 2 * TARG_WIDTH;
    localparam int MAG_WIDTH    = TARG_WIDTH + 1;

    localparam logic [MAG_WIDTH-1:0] COORD_MAX = MAG_WIDTH'((1 << (COORD_WIDTH - 1)) - 1);

    typedef enum logic [1:0] {
        NUM_CANTOR  = 2'd0,
        NUM_SIGNED  = 2'd1,
        NUM_TRI     = 2'd2,
        NUM_TRI_OFS = 2'd3
    } numbering_t;

    localparam logic KIND_PAIR   = 1'b0;
    localparam logic KIND_UNPAIR = 1'b1;

    typedef struct packed {
        logic                    valid;
        logic                    kind;
        numbering_t              mode;
        logic                    bad;
        logic                    sx;
        logic                    sy;
        logic [COORD_WIDTH:0]    targ;
        logic [COORD_WIDTH-1:0]  addend;
        logic [IDX_WIDTH-1:0]    n;
        logic [REM_WIDTH-1:0]    rem;
        logic [ROOT_WIDTH-1:0]   root;
        logic [RADPAD_WIDTH-1:0] rad;
    } lane_t;

endpackage

`default_nettype wire

@@ rtl/core/pairing_function_codec_core.sv @@
// ----------------------------------------------------------------------------
// Pairing function codec core
// Pairs two coordinates into one index or unpairs an index into two
// coordinates, under one of four configured numberings.
// ----------------------------------------------------------------------------
//
//  Channel    Signals                                        Handshake
//  ---------  ---------------------------------------------  -----------------------
//  command    start, kind, first_coord, second_coord,        start high, busy low
//             index_in
//  result     done, index_out, first_out, second_out,        done high, one cycle
//             out_of_range
//  config     cfg_wr_en, cfg_wr_data                         cfg_wr_en high
//
// Commands transfer in every cycle with busy low; items never wait on one another.
// The result strobe follows the accepting edge through one input stage, ROOT_WIDTH
// square root cells, the argument select, the triangular multiplier and the output
// register. Each item carries its numbering.
// busy is high only from reset until the first clock edge after reset is released.
// The result side has no back-pressure, so nothing in the pipeline ever stalls.
// The user writes configuration only between items; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pairing_function_codec_core_defines.svh"

module pairing_function_codec_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              kind,
    input  wire logic signed [pfc_pkg::COORD_WIDTH-1:0] first_coord,
    input  wire logic signed [pfc_pkg::COORD_WIDTH-1:0] second_coord,
    input  wire logic        [pfc_pkg::IDX_WIDTH-1:0]   index_in,
    input  wire logic                              cfg_wr_en,
    input  wire logic        [1:0]                 cfg_wr_data,
    output logic                                   done,
    output logic        [pfc_pkg::IDX_WIDTH-1:0]   index_out,
    output logic signed [pfc_pkg::COORD_WIDTH-1:0] first_out,
    output logic signed [pfc_pkg::COORD_WIDTH-1:0] second_out,
    output logic                                   out_of_range
);
    import pfc_pkg::*;

    // Clock edges from the accepting edge to the edge that takes the result.
    localparam int LATENCY = ROOT_WIDTH + 4;

    numbering_t             numbering_reg;
    numbering_t             numbering_next;
    logic                   busy_reg;
    logic                   accept;
    logic [COORD_WIDTH-1:0] ax;
    logic [COORD_WIDTH-1:0] ay;
    logic [COORD_WIDTH:0]   mag_sum;
    logic                   any_neg;
    logic [IDX_WIDTH-1:0]   m_sel;
    lane_t                  head_next;
    lane_t                  head_reg;
    logic                   head_valid_reg;
    lane_t                  head;
    lane_t                  lane [0:ROOT_WIDTH];

    // The numbering register is the only configuration; writes are registered.
    always_comb
    begin
        numbering_next = cfg_wr_en ? numbering_t'(cfg_wr_data) : numbering_reg;
    end

    assign accept = start && !busy_reg;

    // Input stage. Pairing needs only magnitudes, a sum and the sign bits; the
    // sign tests for the unsigned numberings are settled here and carried as a
    // single flag. Unpairing loads the radicand 8m+1, where m is the index, or
    // the index without its two sign bits in the signed numbering.
    always_comb
    begin
        ax      = first_coord[COORD_WIDTH-1]  ? (COORD_WIDTH'(0) - first_coord)  : first_coord;
        ay      = second_coord[COORD_WIDTH-1] ? (COORD_WIDTH'(0) - second_coord) : second_coord;
        mag_sum = {1'b0, ax} + {1'b0, ay};
        any_neg = first_coord[COORD_WIDTH-1] || second_coord[COORD_WIDTH-1];
        m_sel   = (numbering_reg == NUM_SIGNED) ? {2'b00, index_in[IDX_WIDTH-1:2]} : index_in;

        head_next       = '0;
        head_next.valid = accept;
        head_next.kind  = kind;
        head_next.mode  = numbering_reg;
        head_next.sx    = first_coord[COORD_WIDTH-1];
        head_next.sy    = second_coord[COORD_WIDTH-1];
        head_next.n     = index_in;
        head_next.rad   = RADPAD_WIDTH'({m_sel, 3'b001});
        case (numbering_reg)
            NUM_CANTOR:
            begin
                head_next.bad    = any_neg;
                head_next.targ   = mag_sum;
                head_next.addend = ax;
            end
            NUM_SIGNED:
            begin
                head_next.bad    = 1'b0;
                head_next.targ   = mag_sum;
                head_next.addend = ax;
            end
            NUM_TRI:
            begin
                head_next.bad    = any_neg;
                head_next.targ   = {1'b0, ax};
                head_next.addend = ay;
            end
            NUM_TRI_OFS:
            begin
                // The first coordinate must be at least one here.
                head_next.bad    = any_neg || (first_coord == '0);
                head_next.targ   = {1'b0, ax} - (COORD_WIDTH + 1)'(1);
                head_next.addend = ay;
            end
            default:
            begin
                head_next.bad    = any_neg;
                head_next.targ   = mag_sum;
                head_next.addend = ax;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            numbering_reg  <= NUM_CANTOR;
            busy_reg       <= 1'b1;
            head_valid_reg <= 1'b0;
        end
        else
        begin
            numbering_reg  <= numbering_next;
            busy_reg       <= 1'b0;
            head_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
    end

    always_comb
    begin
        head       = head_reg;
        head.valid = head_valid_reg;
    end

    assign lane[0] = head;

    // The square root row: each cell settles one root bit, most significant
    // first, and hands remainder, partial root and the shifted radicand on.
    for (genvar i = 0; i < ROOT_WIDTH; i++)
    begin : g_cell
        pfc_sqrt_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .d     (lane[i]),
            .q     (lane[i+1])
        );
    end

    // Turns the root into the triangular argument, multiplies it out and forms
    // the index or the coordinates with the range flag.
    pfc_post u_post (
        .clk          (clk),
        .rst_n        (rst_n),
        .d            (lane[ROOT_WIDTH]),
        .done         (done),
        .index_out    (index_out),
        .first_out    (first_out),
        .second_out   (second_out),
        .out_of_range (out_of_range)
    );

    assign busy = busy_reg;

    `PFC_ASSERT_IMP(a_flag_clears_payload, done && out_of_range,
        (index_out == '0) && (first_out == '0) && (second_out == '0),
        "flagged result carries a nonzero payload")
    `PFC_ASSERT_IMP(a_fixed_latency, 1'b1, done == $past(start && !busy, LATENCY),
        "result strobe does not match the accepted command stream")
    `PFC_ASSERT_IMP(a_unsigned_coords, done && (numbering_reg != NUM_SIGNED),
        !first_out[COORD_WIDTH-1] && !second_out[COORD_WIDTH-1],
        "negative coordinate from an unsigned numbering")
    `PFC_ASSERT_NXT(a_busy_stays_low, !busy, !busy,
        "busy raised outside reset")

endmodule

`default_nettype wire

@@ rtl/core/pfc_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// Pairing function codec: square root cell
// One restoring square root digit per cell; the rest of the lane rides along.
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_sqrt_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire pfc_pkg::lane_t d,
    output pfc_pkg::lane_t     q
);
    import pfc_pkg::*;

    logic [REM_WIDTH+1:0] rem_sh;
    logic [REM_WIDTH+1:0] trial;
    logic [REM_WIDTH+1:0] diff;
    logic                 take;
    lane_t                lane_next;
    lane_t                lane_reg;
    logic                 valid_reg;

    always_comb
    begin
        rem_sh    = {d.rem, d.rad[RADPAD_WIDTH-1 -: 2]};
        trial     = {1'b0, d.root, 2'b01};
        take      = (rem_sh >= trial);
        diff      = rem_sh - trial;
        lane_next = d;
        lane_next.rem  = take ? diff[REM_WIDTH-1:0] : rem_sh[REM_WIDTH-1:0];
        lane_next.root = {d.root[ROOT_WIDTH-2:0], take};
        lane_next.rad  = {d.rad[RADPAD_WIDTH-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= d.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        lane_reg <= lane_next;
    end

    always_comb
    begin
        q       = lane_reg;
        q.valid = valid_reg;
    end

endmodule

`default_nettype wire

@@ rtl/core/pfc_post.sv @@
// ----------------------------------------------------------------------------
// Pairing function codec: result stages
// Picks the triangular argument, multiplies it out and forms the result.
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_post (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire pfc_pkg::lane_t                    d,
    output logic                                   done,
    output logic        [pfc_pkg::IDX_WIDTH-1:0]   index_out,
    output logic signed [pfc_pkg::COORD_WIDTH-1:0] first_out,
    output logic signed [pfc_pkg::COORD_WIDTH-1:0] second_out,
    output logic                                   out_of_range
);
    import pfc_pkg::*;

    localparam int PROD_WIDTH = 2 * TARG_WIDTH + 1;
    localparam int FULL_WIDTH = TRI_WIDTH + 3;

    typedef struct packed {
        logic                   kind;
        numbering_t             mode;
        logic                   bad;
        logic                   sx;
        logic                   sy;
        logic [COORD_WIDTH-1:0] addend;
        logic [IDX_WIDTH-1:0]   n;
        logic [TARG_WIDTH-1:0]  s;
    } st1_t;

    typedef struct packed {
        st1_t                  b;
        logic [TRI_WIDTH-1:0]  tri_sum;
    } st2_t;

    // Stage one: argument select.
    logic [TARG_WIDTH-1:0] s_unp;
    st1_t                  st1_next;
    st1_t                  st1_reg;
    logic                  st1_valid_reg;

    // Stage two: triangular number.
    logic [TARG_WIDTH:0]   s_inc;
    logic [PROD_WIDTH-1:0] prod;
    st2_t                  st2_next;
    st2_t                  st2_reg;
    logic                  st2_valid_reg;

    // Result forming.
    logic [TRI_WIDTH:0]     base;
    logic [FULL_WIDTH-1:0]  idx_full;
    logic                   pair_flag;
    logic [IDX_WIDTH-1:0]   n_sel;
    logic [IDX_WIDTH-1:0]   diff_full;
    logic [MAG_WIDTH-1:0]   diff;
    logic [MAG_WIDTH-1:0]   s_ext;
    logic [MAG_WIDTH-1:0]   ux;
    logic [MAG_WIDTH-1:0]   uy;
    logic [MAG_WIDTH-1:0]   lim_x;
    logic [MAG_WIDTH-1:0]   lim_y;
    logic [MAG_WIDTH-1:0]   fx;
    logic [MAG_WIDTH-1:0]   fy;
    logic                   is_signed;
    logic                   unp_flag;
    logic                   flag;
    logic [IDX_WIDTH-1:0]   index_next;
    logic [COORD_WIDTH-1:0] first_next;
    logic [COORD_WIDTH-1:0] second_next;
    logic                   done_reg;
    logic [IDX_WIDTH-1:0]   index_reg;
    logic [COORD_WIDTH-1:0] first_reg;
    logic [COORD_WIDTH-1:0] second_reg;
    logic                   flag_reg;

    // The largest s with (2s+1)^2 <= q^2 comes from the largest odd number not above q.
    always_comb
    begin
        s_unp           = d.root[ROOT_WIDTH-1:1] - TARG_WIDTH'(!d.root[0]);
        st1_next.kind   = d.kind;
        st1_next.mode   = d.mode;
        st1_next.bad    = d.bad;
        st1_next.sx     = d.sx;
        st1_next.sy     = d.sy;
        st1_next.addend = d.addend;
        st1_next.n      = d.n;
        st1_next.s      = (d.kind == KIND_PAIR) ? TARG_WIDTH'(d.targ) : s_unp;
    end

    always_comb
    begin
        s_inc            = {1'b0, st1_reg.s} + (TARG_WIDTH + 1)'(1);
        prod             = PROD_WIDTH'(st1_reg.s) * PROD_WIDTH'(s_inc);
        st2_next.b       = st1_reg;
        st2_next.tri_sum = prod[PROD_WIDTH-1:1];
    end

    always_comb
    begin
        is_signed = (st2_reg.b.mode == NUM_SIGNED);

        // Pairing.
        base = {1'b0, st2_reg.tri_sum} + (TRI_WIDTH + 1)'(st2_reg.b.addend);
        if (is_signed)
        begin
            idx_full = {base, st2_reg.b.sy, st2_reg.b.sx};
        end
        else
        begin
            idx_full = FULL_WIDTH'(base);
        end
        pair_flag = st2_reg.b.bad || (|idx_full[FULL_WIDTH-1:IDX_WIDTH]);

        // Unpairing. The triangular number never exceeds the index here.
        n_sel     = is_signed ? {2'b00, st2_reg.b.n[IDX_WIDTH-1:2]} : st2_reg.b.n;
        diff_full = n_sel - st2_reg.tri_sum[IDX_WIDTH-1:0];
        diff      = diff_full[MAG_WIDTH-1:0];
        s_ext     = {1'b0, st2_reg.b.s};
        case (st2_reg.b.mode)
            NUM_CANTOR,
            NUM_SIGNED:
            begin
                ux = diff;
                uy = s_ext - diff;
            end
            NUM_TRI:
            begin
                ux = s_ext;
                uy = diff;
            end
            NUM_TRI_OFS:
            begin
                ux = s_ext + MAG_WIDTH'(1);
                uy = diff;
            end
            default:
            begin
                ux = diff;
                uy = s_ext - diff;
            end
        endcase
        // A negated magnitude may reach one past the positive limit.
        lim_x    = COORD_MAX + MAG_WIDTH'(is_signed && st2_reg.b.n[0]);
        lim_y    = COORD_MAX + MAG_WIDTH'(is_signed && st2_reg.b.n[1]);
        unp_flag = (ux > lim_x) || (uy > lim_y);
        fx       = (is_signed && st2_reg.b.n[0]) ? (MAG_WIDTH'(0) - ux) : ux;
        fy       = (is_signed && st2_reg.b.n[1]) ? (MAG_WIDTH'(0) - uy) : uy;

        flag = (st2_reg.b.kind == KIND_UNPAIR) ? unp_flag : pair_flag;
        if (flag)
        begin
            index_next  = '0;
            first_next  = '0;
            second_next = '0;
        end
        else if (st2_reg.b.kind == KIND_PAIR)
        begin
            index_next  = idx_full[IDX_WIDTH-1:0];
            first_next  = '0;
            second_next = '0;
        end
        else
        begin
            index_next  = '0;
            first_next  = fx[COORD_WIDTH-1:0];
            second_next = fy[COORD_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            st1_valid_reg <= d.valid;
            st2_valid_reg <= st1_valid_reg;
            done_reg      <= st2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        st1_reg    <= st1_next;
        st2_reg    <= st2_next;
        index_reg  <= index_next;
        first_reg  <= first_next;
        second_reg <= second_next;
        flag_reg   <= flag;
    end

    assign done         = done_reg;
    assign index_out    = index_reg;
    assign first_out    = first_reg;
    assign second_out   = second_reg;
    assign out_of_range = flag_reg;

endmodule

`default_nettype wire

@@ tb/pairing_function_codec_checker.sv @@
// ----------------------------------------------------------------------------
// Pairing function codec checker
// Watches the command, result and configuration channels, works out the
// expected result of every command transfer and compares the results in order.
// ----------------------------------------------------------------------------
module pairing_function_codec_checker (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    input  wire logic                                   busy,
    input  wire logic                                   kind,
    input  wire logic signed [pfc_pkg::COORD_WIDTH-1:0] first_coord,
    input  wire logic signed [pfc_pkg::COORD_WIDTH-1:0] second_coord,
    input  wire logic        [pfc_pkg::IDX_WIDTH-1:0]   index_in,
    input  wire logic                                   cfg_wr_en,
    input  wire logic        [1:0]                      cfg_wr_data,
    input  wire logic                                   done,
    input  wire logic        [pfc_pkg::IDX_WIDTH-1:0]   index_out,
    input  wire logic signed [pfc_pkg::COORD_WIDTH-1:0] first_out,
    input  wire logic signed [pfc_pkg::COORD_WIDTH-1:0] second_out,
    input  wire logic                                   out_of_range,
    output int unsigned                                 mismatches,
    output int unsigned                                 pending
);
    import pfc_pkg::*;

    typedef struct packed {
        logic [IDX_WIDTH-1:0]   index;
        logic [COORD_WIDTH-1:0] first;
        logic [COORD_WIDTH-1:0] second;
        logic                   flag;
    } codec_result_t;

    numbering_t    numbering = NUM_CANTOR;
    codec_result_t expected_results[$];
    int unsigned   fail_tally = 0;

    assign mismatches = fail_tally;

    initial pending = 0;

    // Arguments stay below 2^19 here, so the product never overflows 64 bits.
    function automatic longint unsigned triangle_num(input longint unsigned s);
        return (s * (s + 1)) >> 1;
    endfunction

    // Largest s with s(s+1)/2 <= n, found by bisection.
    function automatic longint unsigned triangle_root(input longint unsigned n);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        lo = 0;
        hi = 64'd1 << 19;
        while (hi - lo > 1) begin
            mid = lo + (hi - lo) / 2;
            if (triangle_num(mid) <= n)
                lo = mid;
            else
                hi = mid;
        end
        return lo;
    endfunction

    function automatic codec_result_t predict_result(
        input numbering_t                     mode,
        input logic                           op,
        input logic signed [COORD_WIDTH-1:0]  x_in,
        input logic signed [COORD_WIDTH-1:0]  y_in,
        input logic        [IDX_WIDTH-1:0]    n_in
    );
        longint          x, y, xe, fx, fy, cmax;
        longint unsigned ax, ay, s, m, ux, uy, idx, n;
        bit              flag;
        codec_result_t   r;
        x    = x_in;
        y    = y_in;
        n    = n_in;
        cmax = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
        flag = 1'b0;
        idx  = 0;
        fx   = 0;
        fy   = 0;
        if (op == KIND_PAIR) begin
            if (mode == NUM_SIGNED) begin
                ax  = (x < 0) ? -x : x;
                ay  = (y < 0) ? -y : y;
                idx = (triangle_num(ax + ay) + ax) * 4;
                if (x < 0) idx += 1;
                if (y < 0) idx += 2;
            end else if (mode == NUM_CANTOR) begin
                if (x < 0 || y < 0)
                    flag = 1'b1;
                else
                    idx = triangle_num(x + y) + x;
            end else begin
                xe = (mode == NUM_TRI_OFS) ? x - 1 : x;
                if (xe < 0 || y < 0)
                    flag = 1'b1;
                else
                    idx = triangle_num(xe) + y;
            end
            if (idx >> IDX_WIDTH != 0)
                flag = 1'b1;
        end else begin
            if (mode == NUM_CANTOR || mode == NUM_SIGNED) begin
                m  = (mode == NUM_SIGNED) ? n >> 2 : n;
                s  = triangle_root(m);
                ux = m - triangle_num(s);
                uy = s - ux;
            end else begin
                ux = triangle_root(n);
                uy = n - triangle_num(ux);
                if (mode == NUM_TRI_OFS)
                    ux += 1;
            end
            if (mode == NUM_SIGNED) begin
                // A negative coordinate may reach one step further than a positive one.
                if (ux > cmax + n[0] || uy > cmax + n[1]) begin
                    flag = 1'b1;
                end else begin
                    fx = n[0] ? -longint'(ux) : longint'(ux);
                    fy = n[1] ? -longint'(uy) : longint'(uy);
                end
            end else if (ux > cmax || uy > cmax) begin
                flag = 1'b1;
            end else begin
                fx = ux;
                fy = uy;
            end
        end
        if (flag) begin
            idx = 0;
            fx  = 0;
            fy  = 0;
        end
        r.index  = idx[IDX_WIDTH-1:0];
        r.first  = fx[COORD_WIDTH-1:0];
        r.second = fy[COORD_WIDTH-1:0];
        r.flag   = flag;
        return r;
    endfunction

    function automatic int field_differs(input string name, input logic [63:0] want,
                                         input logic [63:0] got);
        if (want === got)
            return 0;
        $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        return 1;
    endfunction

    always @(posedge clk) begin
        codec_result_t want;
        if (!rst_n) begin
            numbering = NUM_CANTOR;
        end else begin
            // The oldest expectation is taken before this edge's transfer is added.
            if (done) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result expected none, got index %0h first %0h",
                             $time, index_out, first_out);
                    $display("%0t: second %0h flag %0b", $time, second_out, out_of_range);
                    fail_tally++;
                end else begin
                    want = expected_results.pop_front();
                    fail_tally += field_differs("index_out", want.index, index_out)
                                + field_differs("first_out", want.first,
                                                $unsigned(first_out))
                                + field_differs("second_out", want.second,
                                                $unsigned(second_out))
                                + field_differs("out_of_range", want.flag, out_of_range);
                end
            end
            if (start && !busy)
                expected_results.push_back(predict_result(numbering, kind, first_coord,
                                                          second_coord, index_in));
            if (cfg_wr_en)
                numbering = numbering_t'(cfg_wr_data);
            pending = expected_results.size();
        end
    end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Pairing function codec testbench
// Drives directed and random pair and unpair commands under every numbering,
// with bursts and gaps on the command side; the checker beside the block
// predicts and compares every result and this top gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

    import pfc_pkg::*;

    localparam int CW      = COORD_WIDTH;
    localparam int IW      = IDX_WIDTH;
    // Accepting edge to result strobe.
    localparam int LATENCY = ROOT_WIDTH + 3;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_ITEMS = 225;

    localparam logic signed [CW-1:0] C_MAX  = {1'b0, {(CW - 1){1'b1}}};
    localparam logic signed [CW-1:0] C_MIN  = {1'b1, {(CW - 1){1'b0}}};
    localparam logic signed [CW-1:0] C_ZERO = '0;
    localparam logic [IW-1:0] IDX_ALL_ONES = {IW{1'b1}};
    localparam longint unsigned HALF = 64'd1 << (CW - 1);
    // Signed Cantor index whose first coordinate decodes to the most negative value.
    localparam logic [IW-1:0] IDX_SIGNED_MIN = IW'(4 * (HALF * (HALF + 1) / 2 + HALF) + 1);
    // Plain Cantor index that decodes to both coordinates at their maximum.
    localparam logic [IW-1:0] IDX_CANTOR_MAX = IW'((2 * HALF - 2) * (2 * HALF - 1) / 2 + HALF - 1);

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 kind = KIND_PAIR;
    logic signed [CW-1:0] first_coord = '0;
    logic signed [CW-1:0] second_coord = '0;
    logic        [IW-1:0] index_in = '0;
    logic                 cfg_wr_en = 1'b0;
    logic        [1:0]    cfg_wr_data = NUM_CANTOR;
    logic                 done;
    logic        [IW-1:0] index_out;
    logic signed [CW-1:0] first_out;
    logic signed [CW-1:0] second_out;
    logic                 out_of_range;
    int unsigned          mismatches;
    int unsigned          pending;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    pairing_function_codec_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .first_coord  (first_coord),
        .second_coord (second_coord),
        .index_in     (index_in),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .done         (done),
        .index_out    (index_out),
        .first_out    (first_out),
        .second_out   (second_out),
        .out_of_range (out_of_range)
    );

    pairing_function_codec_checker checker_inst (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .first_coord  (first_coord),
        .second_coord (second_coord),
        .index_in     (index_in),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .done         (done),
        .index_out    (index_out),
        .first_out    (first_out),
        .second_out   (second_out),
        .out_of_range (out_of_range),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    // Inputs change on the falling edge; the command stays up until an edge
    // with busy low completes the transfer.
    task automatic send_cmd(input logic op, input logic signed [CW-1:0] x,
                            input logic signed [CW-1:0] y, input logic [IW-1:0] n);
        @(negedge clk);
        kind         = op;
        first_coord  = x;
        second_coord = y;
        index_in     = n;
        start        = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic pair_item(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y);
        send_cmd(KIND_PAIR, x, y, IW'({$urandom, $urandom}));
    endtask

    task automatic unpair_item(input logic [IW-1:0] n);
        send_cmd(KIND_UNPAIR, CW'($urandom), CW'($urandom), n);
    endtask

    // Idle cycles carry junk on the payload, which the block must ignore.
    task automatic idle_cycles(input int count);
        repeat (count) begin
            @(negedge clk);
            start        = 1'b0;
            kind         = 1'($urandom);
            first_coord  = CW'($urandom);
            second_coord = CW'($urandom);
            index_in     = IW'({$urandom, $urandom});
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        start = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic set_numbering(input numbering_t mode);
        drain_results();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = mode;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
    endtask

    // Mostly small magnitudes of random width, with the extremes now and then.
    function automatic logic signed [CW-1:0] random_coord(input bit neg_ok);
        logic signed [CW-1:0] v;
        int                   w;
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 3))
                    0: v = C_MAX;
                    1: v = C_MIN;
                    2: v = C_ZERO;
                    default: v = '1;
                endcase
            end
            1: v = CW'($urandom);
            default: begin
                w = $urandom_range(1, CW - 1);
                v = CW'($urandom & ((32'd1 << w) - 1));
                if ($urandom_range(0, 1) == 1)
                    v = -v;
            end
        endcase
        if (!neg_ok)
            v[CW-1] = 1'b0;
        return v;
    endfunction

    // A random bit width gives an even spread of index magnitudes.
    function automatic logic [IW-1:0] random_index();
        logic [63:0] v;
        int          w;
        w = $urandom_range(1, IW);
        v = {$urandom, $urandom};
        return IW'(v & ((64'd1 << w) - 1));
    endfunction

    task automatic run_random(input numbering_t mode, input int count);
        int left;
        int burst;
        bit neg_ok;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 40);
            if (burst > left)
                burst = left;
            left -= burst;
            repeat (burst) begin
                if ($urandom_range(0, 1) == 0) begin
                    // Unsigned numberings see a negative coordinate only now and then.
                    neg_ok = (mode == NUM_SIGNED) || ($urandom_range(0, 9) == 0);
                    pair_item(random_coord(neg_ok), random_coord(neg_ok));
                end else begin
                    unpair_item(random_index());
                end
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3: ;
                9: idle_cycles($urandom_range(20, 30));
                default: idle_cycles($urandom_range(1, 6));
            endcase
            if ($urandom_range(0, 39) == 0)
                drain_results();
        end
    endtask

    numbering_t random_plan[8] = '{NUM_TRI_OFS, NUM_CANTOR, NUM_SIGNED, NUM_TRI,
                                   NUM_SIGNED, NUM_CANTOR, NUM_TRI_OFS, NUM_TRI};

    initial begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Plain Cantor straight from reset, without a register write.
        pair_item(C_ZERO, C_ZERO);
        pair_item(C_MAX, C_MAX);
        pair_item(-16'sd1, 16'sd3);
        pair_item(16'sd5, C_MIN);
        unpair_item('0);
        unpair_item(IDX_ALL_ONES);
        unpair_item(IDX_CANTOR_MAX);

        // Signed Cantor: sign bits on zero magnitudes and the most negative decode.
        set_numbering(NUM_SIGNED);
        pair_item(C_MIN, C_MIN);
        pair_item(C_MAX, -16'sd1);
        pair_item(C_ZERO, C_ZERO);
        unpair_item(IW'(1));
        unpair_item(IW'(3));
        unpair_item(IDX_SIGNED_MIN);
        unpair_item(IDX_ALL_ONES);

        set_numbering(NUM_TRI);
        pair_item(C_ZERO, C_ZERO);
        pair_item(C_MAX, C_MAX);
        pair_item(C_MIN, C_ZERO);
        pair_item(16'sd3, -16'sd1);
        unpair_item(IDX_ALL_ONES);

        // Offset triangular: a first coordinate below one is out of range.
        set_numbering(NUM_TRI_OFS);
        pair_item(C_ZERO, 16'sd5);
        pair_item(16'sd1, C_ZERO);
        pair_item(C_MIN, C_MAX);
        pair_item(C_MAX, C_MAX);
        unpair_item('0);
        unpair_item(IDX_ALL_ONES);

        foreach (random_plan[i]) begin
            set_numbering(random_plan[i]);
            run_random(random_plan[i], PHASE_ITEMS);
        end

        drain_results();
        repeat (LATENCY + 8) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Ends the run when neither channel has made a transfer for too long.
    initial begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (start && !busy) || done)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/pfc_pkg.sv
rtl/core/pfc_sqrt_cell.sv
rtl/core/pfc_post.sv
rtl/core/pairing_function_codec_core.sv
tb/pairing_function_codec_checker.sv
tb/testbench.sv
